/* hdl/wtps_pkg.sv */
// Shared types and constants for the waypoint teach/playback sequencer.
// Standalone package; used by the step logic and by the top level.
`default_nettype none

package wtps_pkg;

	// Slot store geometry.
	localparam int NUM_SLOTS   = 10;
	localparam int SLOT_W      = 4;
	localparam int SLOT_AW     = $clog2(NUM_SLOTS);
	localparam int POS_W       = 16;
	localparam int SLOT_PAIR_W = 2 * POS_W;
	localparam int CMD_W       = 5;
	localparam int CFG_DATA_W  = 8;
	localparam int DWELL_W     = 8;

	// Remote command codes; codes below NUM_SLOTS are digits.
	localparam logic [CMD_W-1:0] CMD_PLAY   = 5'd10;
	localparam logic [CMD_W-1:0] CMD_STOP   = 5'd11;
	localparam logic [CMD_W-1:0] CMD_B_UP   = 5'd12;
	localparam logic [CMD_W-1:0] CMD_B_DOWN = 5'd13;
	localparam logic [CMD_W-1:0] CMD_A_UP   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_A_DOWN = 5'd15;
	localparam logic [CMD_W-1:0] CMD_RECORD = 5'd16;
	localparam logic [CMD_W-1:0] CMD_GO     = 5'd17;

	// Operating modes.
	typedef enum logic [2:0] {
		MODE_AUTO_NEXT = 3'd0,
		MODE_AUTO_WAIT = 3'd1,
		MODE_MANUAL    = 3'd2,
		MODE_RECORD    = 3'd3,
		MODE_GO        = 3'd4
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_JOG_STEP     = 2'd0,
		CFG_CLAMP_WINDOW = 2'd1,
		CFG_SETTLE_TOL   = 2'd2,
		CFG_DWELL_LIMIT  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] jog_step;
		logic [CFG_DATA_W-1:0] clamp_window;
		logic [CFG_DATA_W-1:0] settle_tolerance;
		logic [CFG_DATA_W-1:0] dwell_limit;
	} cfg_t;

	// One control-loop tick.
	typedef struct packed {
		logic                    command_valid;
		logic [CMD_W-1:0]        command;
		logic signed [POS_W-1:0] position_a;
		logic signed [POS_W-1:0] position_b;
	} in_item_t;

	// One result per tick.
	typedef struct packed {
		logic signed [POS_W-1:0] setpoint_a;
		logic signed [POS_W-1:0] setpoint_b;
		logic [2:0]              mode;
		logic [SLOT_W-1:0]       slot_index;
		logic [DWELL_W-1:0]      dwell_count;
	} out_item_t;

	// Both axes of one stored waypoint.
	typedef struct packed {
		logic signed [POS_W-1:0] a;
		logic signed [POS_W-1:0] b;
	} slot_pair_t;

	// Architectural sequencer state.
	typedef struct packed {
		mode_t                   mode;
		logic [SLOT_W-1:0]       slot;
		logic [DWELL_W-1:0]      dwell;
		logic signed [POS_W-1:0] tgt_a;
		logic signed [POS_W-1:0] tgt_b;
	} seq_state_t;

	// Slot store write request from the step logic.
	typedef struct packed {
		logic               we;
		logic [SLOT_AW-1:0] addr;
		slot_pair_t         data;
	} slot_wr_t;

endpackage

`default_nettype wire

/* hdl/wtps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wtps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/wtps_step.sv */
// Per-tick update of the sequencer: commands, jog and clamp, record/go, playback.
// Depends on wtps_pkg. Purely combinational; slot data comes from the slot store.
`default_nettype none

module wtps_step (
	input  wtps_pkg::seq_state_t st,
	input  wtps_pkg::in_item_t   item,
	input  wtps_pkg::cfg_t       cfg,
	input  wtps_pkg::slot_pair_t sd,
	output wtps_pkg::seq_state_t nxt,
	output wtps_pkg::slot_wr_t   wr
);
	import wtps_pkg::*;

	// Saturate a 17-bit signed value to 16 bits.
	function automatic logic signed [POS_W-1:0] sat16(input logic signed [POS_W:0] v);
		if (v[POS_W] != v[POS_W-1]) begin
			return v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		return v[POS_W-1:0];
	endfunction

	// Keep a setpoint within a window around the measured position.
	function automatic logic signed [POS_W-1:0] clamp_to(
		input logic signed [POS_W-1:0] sp,
		input logic signed [POS_W-1:0] pos,
		input logic [CFG_DATA_W-1:0]   w
	);
		logic signed [POS_W:0] spx;
		logic signed [POS_W:0] px;
		logic signed [POS_W:0] wx;
		logic signed [POS_W:0] hi;
		logic signed [POS_W:0] lo;
		spx = {sp[POS_W-1], sp};
		px  = {pos[POS_W-1], pos};
		wx  = {{(POS_W+1-CFG_DATA_W){1'b0}}, w};
		hi  = px + wx;
		lo  = px - wx;
		if (spx > hi) begin
			return sat16(hi);
		end
		if (spx < lo) begin
			return sat16(lo);
		end
		return sp;
	endfunction

	// Jog a setpoint up or down by the step size, saturating.
	function automatic logic signed [POS_W-1:0] jog(
		input logic signed [POS_W-1:0] sp,
		input logic [CFG_DATA_W-1:0]   js,
		input logic                    down
	);
		logic signed [POS_W:0] spx;
		logic signed [POS_W:0] jx;
		spx = {sp[POS_W-1], sp};
		jx  = {{(POS_W+1-CFG_DATA_W){1'b0}}, js};
		return down ? sat16(spx - jx) : sat16(spx + jx);
	endfunction

	// Strict tolerance check on one axis.
	function automatic logic near(
		input logic signed [POS_W-1:0] a,
		input logic signed [POS_W-1:0] b,
		input logic [CFG_DATA_W-1:0]   tol
	);
		logic signed [POS_W+1:0] d;
		logic signed [POS_W+1:0] t;
		d = {{2{a[POS_W-1]}}, a} - {{2{b[POS_W-1]}}, b};
		t = {{(POS_W+2-CFG_DATA_W){1'b0}}, tol};
		return (d < t) && (d > -t);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	logic                 is_digit;
	logic                 occupied;
	logic                 settled;
	logic [DWELL_W:0]     dwell_inc;

	assign is_digit = item.command < CMD_W'(NUM_SLOTS);
	assign occupied = (sd.a != '0) && (sd.b != '0);
	assign settled  = near(sd.a, item.position_a, cfg.settle_tolerance)
		&& near(sd.b, item.position_b, cfg.settle_tolerance);

	// Command phase followed by the playback phase, in that order.
	always_comb begin
		nxt       = st;
		wr.we     = 1'b0;
		wr.addr   = item.command[SLOT_AW-1:0];
		wr.data   = '{a: st.tgt_a, b: st.tgt_b};
		dwell_inc = '0;

		if (item.command_valid) begin
			if (item.command == CMD_PLAY) begin
				nxt.mode = MODE_AUTO_NEXT;
				nxt.slot = '0;
			end else if (item.command == CMD_STOP) begin
				nxt.mode = MODE_MANUAL;
			end else begin
				unique case (st.mode)
					MODE_MANUAL: begin
						case (item.command)
							CMD_B_UP:   nxt.tgt_b = jog(st.tgt_b, cfg.jog_step, 1'b0);
							CMD_B_DOWN: nxt.tgt_b = jog(st.tgt_b, cfg.jog_step, 1'b1);
							CMD_A_UP:   nxt.tgt_a = jog(st.tgt_a, cfg.jog_step, 1'b0);
							CMD_A_DOWN: nxt.tgt_a = jog(st.tgt_a, cfg.jog_step, 1'b1);
							CMD_RECORD: nxt.mode  = MODE_RECORD;
							CMD_GO:     nxt.mode  = MODE_GO;
							default: ;
						endcase
						// The clamp applies on every manual command other than play and stop.
						nxt.tgt_a = clamp_to(nxt.tgt_a, item.position_a, cfg.clamp_window);
						nxt.tgt_b = clamp_to(nxt.tgt_b, item.position_b, cfg.clamp_window);
					end
					MODE_RECORD: begin
						if (item.command != CMD_RECORD) begin
							wr.we    = is_digit;
							nxt.mode = MODE_MANUAL;
						end
					end
					MODE_GO: begin
						if (item.command != CMD_GO) begin
							if (is_digit) begin
								nxt.tgt_a = sd.a;
								nxt.tgt_b = sd.b;
							end
							nxt.mode = MODE_MANUAL;
						end
					end
					default: ;
				endcase
			end
		end

		// Playback: load an occupied slot, or skip past an empty one.
		if (nxt.mode == MODE_AUTO_NEXT) begin
			if (occupied) begin
				nxt.tgt_a = sd.a;
				nxt.tgt_b = sd.b;
				nxt.dwell = '0;
				nxt.mode  = MODE_AUTO_WAIT;
			end else begin
				nxt.slot = next_slot(nxt.slot);
			end
		end

		// Dwell: count settled ticks and advance once past the limit.
		if (nxt.mode == MODE_AUTO_WAIT) begin
			dwell_inc = {1'b0, nxt.dwell} + {{DWELL_W{1'b0}}, settled};
			if (dwell_inc > {1'b0, cfg.dwell_limit}) begin
				nxt.dwell = '0;
				nxt.slot  = next_slot(nxt.slot);
				nxt.mode  = MODE_AUTO_NEXT;
			end else begin
				nxt.dwell = dwell_inc[DWELL_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/waypoint_teach_playback_sequencer.sv */
// Two-axis waypoint teach-and-playback sequencer, top level.
// Depends on wtps_pkg, wtps_ram and wtps_step.
//
// Each input item is one control-loop tick; each produces exactly one result item. The block
// takes one item per clock cycle unless the input stalls, as below. An item and its slot store
// read, which has a registered read port, are captured together in stage 1 at acceptance, and
// its update loads the output register when that register is free or emptying. The slot store
// read address for the next item comes from the update logic of the item in flight, and a
// record into the entry being read in the same cycle is bypassed, so back-to-back items see
// every earlier write. The slot store is empty after reset through one written flag per slot,
// so no clearing pass runs and items are taken from the first cycle. The input stalls only
// while a result waits untaken in the output register and the next item already sits in the
// slot read stage.
`default_nettype none

module waypoint_teach_playback_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wtps_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output wtps_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  wtps_pkg::cfg_idx_t                 cfg_index,
	input  logic [wtps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wtps_pkg::*;

	cfg_t               cfg_q;
	seq_state_t         st_q;
	seq_state_t         nxt;
	seq_state_t         fwd_st;
	slot_wr_t           wr;
	logic               ram_we;
	logic               accept;
	logic               adv;
	logic [SLOT_AW-1:0] raddr;
	logic               byp;
	slot_pair_t         rdata;
	slot_pair_t         sd;
	logic [NUM_SLOTS-1:0] written_q;

	logic               s1_valid_q;
	in_item_t           item_s1;
	logic               byp_s1;
	slot_pair_t         byp_data_s1;
	logic               vld_s1;

	logic               out_valid_q;
	out_item_t          out_q;

	// Handshake: the item in flight leaves when the output register is free or emptying.
	assign adv       = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || adv;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{jog_step: 8'd10, clamp_window: 8'd20,
				settle_tolerance: 8'd10, dwell_limit: 8'd60};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_JOG_STEP:     cfg_q.jog_step         <= cfg_data;
				CFG_CLAMP_WINDOW: cfg_q.clamp_window     <= cfg_data;
				CFG_SETTLE_TOL:   cfg_q.settle_tolerance <= cfg_data;
				CFG_DWELL_LIMIT:  cfg_q.dwell_limit      <= cfg_data;
			endcase
		end
	end

	// State as the incoming item will see it: the in-flight item's result when there is one.
	assign fwd_st = s1_valid_q ? nxt : st_q;

	// Slot to read for the incoming item: play starts at slot zero, go loads a digit slot.
	always_comb begin
		if (in_data.command_valid && in_data.command == CMD_PLAY) begin
			raddr = '0;
		end else if (in_data.command_valid && fwd_st.mode == MODE_GO
				&& in_data.command < CMD_W'(NUM_SLOTS)) begin
			raddr = in_data.command[SLOT_AW-1:0];
		end else begin
			raddr = fwd_st.slot[SLOT_AW-1:0];
		end
	end

	// A record landing on the entry read in the same cycle is bypassed.
	assign ram_we = wr.we && adv;
	assign byp    = ram_we && (wr.addr == raddr);

	wtps_ram #(
		.WIDTH (SLOT_PAIR_W),
		.DEPTH (NUM_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Slots never written read as empty.
	assign sd = byp_s1 ? byp_data_s1 : (vld_s1 ? rdata : '0);

	wtps_step u_step (
		.st   (st_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.sd   (sd),
		.nxt  (nxt),
		.wr   (wr)
	);

	// Written flags for the slot store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[wr.addr] <= 1'b1;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload, captured alongside the slot read.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_data;
			byp_s1      <= byp;
			byp_data_s1 <= wr.data;
			vld_s1      <= written_q[raddr];
		end
	end

	// Sequencer state commits when the item leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_MANUAL, slot: '0, dwell: '0, tgt_a: '0, tgt_b: '0};
		end else if (adv) begin
			st_q <= nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= '{setpoint_a: nxt.tgt_a, setpoint_b: nxt.tgt_b, mode: nxt.mode,
				slot_index: nxt.slot, dwell_count: nxt.dwell};
		end
	end

`ifndef SYNTH
	// A stalled result must freeze the sequencer state.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(st_q))
		else $error("sequencer state changed while a result was stalled");

	// The slot store is written only by an item processed in record mode.
	a_rec_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q.mode == MODE_RECORD))
		else $error("slot store written outside record mode");

	// The playback slot always addresses a real entry.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.slot < SLOT_W'(NUM_SLOTS))
		else $error("playback slot out of range");

	// A new result only follows an item in stage 1.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("result produced without an item in flight");
`endif

endmodule

`default_nettype wire

/* tb/tb_waypoint_teach_playback_sequencer.sv */
// Self-checking testbench for the waypoint teach/playback sequencer.
// Depends on wtps_pkg and the top level; a built-in predictor supplies the expected items.
`timescale 1ns / 1ps

module tb_waypoint_teach_playback_sequencer;
	import wtps_pkg::*;

	localparam int LONG_HOLD = 80;
	localparam int RANDOM_TICKS = 1150;
	localparam int LATENCY_TAIL = 4;
	localparam logic [CMD_W-1:0] CMD_OTHER = 5'd18;
	localparam logic [CMD_W-1:0] CMD_TOP = 5'd31;
	localparam logic signed [POS_W-1:0] POS_MAX = 16'h7FFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 16'h8000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predicted sequencer state and register copies.
	logic [CFG_DATA_W-1:0] jog_step_r = 8'd10;
	logic [CFG_DATA_W-1:0] clamp_win_r = 8'd20;
	logic [CFG_DATA_W-1:0] settle_tol_r = 8'd10;
	logic [CFG_DATA_W-1:0] dwell_lim_r = 8'd60;
	mode_t cur_mode = MODE_MANUAL;
	logic [SLOT_W-1:0] cur_slot = '0;
	logic [DWELL_W-1:0] dwell_ticks = '0;
	logic signed [POS_W-1:0] sp_a = '0;
	logic signed [POS_W-1:0] sp_b = '0;
	logic signed [POS_W-1:0] wp_a [NUM_SLOTS];
	logic signed [POS_W-1:0] wp_b [NUM_SLOTS];

	out_item_t pending_results [$];
	int mismatches = 0;
	int ticks_sent = 0;
	bit src_gaps_on = 1'b0;
	bit sink_stalls_on = 1'b0;
	bit long_hold_req = 1'b0;

	waypoint_teach_playback_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Saturate a wide value to the 16-bit position range.
	function automatic int sat_pos(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Keep a setpoint within the clamp window around its measured position.
	function automatic int clamp_near(input int sp, input int pos);
		int w;
		w = int'(clamp_win_r);
		if (sp > pos + w) return sat_pos(pos + w);
		if (sp < pos - w) return sat_pos(pos - w);
		return sp;
	endfunction

	function automatic bit settled(input int goal, input int pos);
		int d;
		int t;
		d = goal - pos;
		t = int'(settle_tol_r);
		return (d < t) && (d > -t);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (int'(s) + 1 >= NUM_SLOTS) ? '0 : s + 1'b1;
	endfunction

	// Apply one tick to the predicted state and return the item it should produce.
	function automatic out_item_t advance_sequencer(input in_item_t t);
		int pa;
		int pb;
		int js;
		int unsigned n;
		out_item_t r;
		pa = $signed(t.position_a);
		pb = $signed(t.position_b);
		js = int'(jog_step_r);
		if (cur_slot >= NUM_SLOTS) cur_slot = '0;
		if (t.command_valid) begin
			if (t.command == CMD_PLAY) begin
				cur_mode = MODE_AUTO_NEXT;
				cur_slot = '0;
			end else if (t.command == CMD_STOP) begin
				cur_mode = MODE_MANUAL;
			end else if (cur_mode == MODE_MANUAL) begin
				case (t.command)
					CMD_B_UP: sp_b = 16'(sat_pos(int'(sp_b) + js));
					CMD_B_DOWN: sp_b = 16'(sat_pos(int'(sp_b) - js));
					CMD_A_UP: sp_a = 16'(sat_pos(int'(sp_a) + js));
					CMD_A_DOWN: sp_a = 16'(sat_pos(int'(sp_a) - js));
					CMD_RECORD: cur_mode = MODE_RECORD;
					CMD_GO: cur_mode = MODE_GO;
					default: ;
				endcase
				// The clamp runs on every manual command but play and stop, even one that leaves manual.
				sp_a = 16'(clamp_near(int'(sp_a), pa));
				sp_b = 16'(clamp_near(int'(sp_b), pb));
			end else if (cur_mode == MODE_RECORD) begin
				if (t.command != CMD_RECORD) begin
					if (t.command < NUM_SLOTS) begin
						wp_a[t.command] = sp_a;
						wp_b[t.command] = sp_b;
					end
					cur_mode = MODE_MANUAL;
				end
			end else if (cur_mode == MODE_GO) begin
				if (t.command != CMD_GO) begin
					if (t.command < NUM_SLOTS) begin
						sp_a = wp_a[t.command];
						sp_b = wp_b[t.command];
					end
					cur_mode = MODE_MANUAL;
				end
			end
		end
		// Playback: skip empty slots, load the first filled one.
		if (cur_mode == MODE_AUTO_NEXT) begin
			if (wp_a[cur_slot] != 0 && wp_b[cur_slot] != 0) begin
				sp_a = wp_a[cur_slot];
				sp_b = wp_b[cur_slot];
				dwell_ticks = '0;
				cur_mode = MODE_AUTO_WAIT;
			end else begin
				cur_slot = next_slot(cur_slot);
			end
		end
		// Dwell counts settled ticks until it exceeds the limit.
		if (cur_mode == MODE_AUTO_WAIT) begin
			n = dwell_ticks;
			if (settled(wp_a[cur_slot], pa) && settled(wp_b[cur_slot], pb)) n++;
			if (n > dwell_lim_r) begin
				dwell_ticks = '0;
				cur_slot = next_slot(cur_slot);
				cur_mode = MODE_AUTO_NEXT;
			end else begin
				dwell_ticks = n[DWELL_W-1:0];
			end
		end
		r.setpoint_a = sp_a;
		r.setpoint_b = sp_b;
		r.mode = cur_mode;
		r.slot_index = cur_slot;
		r.dwell_count = dwell_ticks;
		return r;
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic signed [POS_W-1:0] rand_pos();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic signed [POS_W-1:0] near_pos(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		return 16'(sat_pos(v));
	endfunction

	function automatic int rand_center();
		int m;
		m = $urandom_range(200, 32767);
		return ($urandom_range(0, 1) == 1) ? m : -m;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare one result item against the oldest prediction.
	function automatic void check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$display("%0t ns: result item with none expected: expected nothing, got %p",
				$time, got);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		check_field("setpoint_a", $signed(want.setpoint_a), $signed(got.setpoint_a));
		check_field("setpoint_b", $signed(want.setpoint_b), $signed(got.setpoint_b));
		check_field("mode", want.mode, got.mode);
		check_field("slot_index", want.slot_index, got.slot_index);
		check_field("dwell_count", want.dwell_count, got.dwell_count);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) check_result(out_data);
	end

	// Result sink: random stalls, plus a long hold-off on request.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one tick, predict its result on acceptance, then maybe leave a gap.
	task automatic send_tick(input in_item_t t);
		int gap;
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(advance_sequencer(t));
		ticks_sent++;
		if (src_gaps_on && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic tick(input bit v, input logic [CMD_W-1:0] cmd,
		input logic signed [POS_W-1:0] pa, input logic signed [POS_W-1:0] pb);
		in_item_t t;
		t.command_valid = v;
		t.command = cmd;
		t.position_a = pa;
		t.position_b = pb;
		send_tick(t);
	endtask

	// Stop offering items and wait until every expected item has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_JOG_STEP: jog_step_r = val;
			CFG_CLAMP_WINDOW: clamp_win_r = val;
			CFG_SETTLE_TOL: settle_tol_r = val;
			CFG_DWELL_LIMIT: dwell_lim_r = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input int jog, input int win, input int tol, input int dwell);
		wait_idle();
		write_reg(CFG_JOG_STEP, 8'(jog));
		write_reg(CFG_CLAMP_WINDOW, 8'(win));
		write_reg(CFG_SETTLE_TOL, 8'(tol));
		write_reg(CFG_DWELL_LIMIT, 8'(dwell));
	endtask

	// Jog around a position, then record the setpoints into a slot.
	task automatic teach_waypoint(input logic [CMD_W-1:0] digit, input int ca, input int cb);
		repeat ($urandom_range(1, 4))
			tick(1'b1, 5'(CMD_B_UP + $urandom_range(0, 3)), near_pos(ca, 30), near_pos(cb, 30));
		tick(1'b1, CMD_RECORD, near_pos(ca, 30), near_pos(cb, 30));
		tick(1'b1, digit, near_pos(ca, 30), near_pos(cb, 30));
	endtask

	// Start playback and feed positions near the active waypoint; noisy unless quiet.
	task automatic play_through(input int n, input bit quiet);
		int tol;
		int spread;
		tol = int'(settle_tol_r);
		tick(1'b1, CMD_PLAY, rand_pos(), rand_pos());
		repeat (n) begin
			spread = ($urandom_range(0, 3) != 0) ? ((tol > 0) ? tol - 1 : 0) : tol + 1;
			if (!quiet && $urandom_range(0, 24) == 0)
				tick(1'b1, 5'($urandom_range(0, 31)), rand_pos(), rand_pos());
			else if (cur_mode != MODE_AUTO_NEXT && cur_mode != MODE_AUTO_WAIT)
				tick(1'b1, CMD_PLAY, rand_pos(), rand_pos());
			else
				tick(!quiet && $urandom_range(0, 9) == 0, 5'($urandom_range(0, 31)),
					near_pos(wp_a[cur_slot], spread), near_pos(wp_b[cur_slot], spread));
		end
		tick(1'b1, CMD_STOP, rand_pos(), rand_pos());
	endtask

	// Field extremes, commands in every mode, and the named corner cases.
	task automatic test_directed_edges();
		src_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		tick(1'b0, CMD_TOP, 16'sd0, 16'sd0);
		tick(1'b1, CMD_A_UP, POS_MAX, POS_MIN);
		tick(1'b1, CMD_A_DOWN, 16'sd0, 16'sd0);
		tick(1'b1, CMD_B_UP, 16'sd0, 16'sd0);
		tick(1'b1, CMD_B_DOWN, 16'sd0, 16'sd0);
		tick(1'b1, CMD_OTHER, 16'sd100, -16'sd100);
		tick(1'b1, CMD_TOP, -16'sd1, -16'sd1);
		tick(1'b1, 5'd7, 16'sd5, 16'sd5);
		// Record into a slot, with a repeated record that must be ignored.
		tick(1'b1, CMD_RECORD, 16'sd300, -16'sd300);
		tick(1'b1, CMD_RECORD, 16'sd300, -16'sd300);
		tick(1'b1, 5'd3, 16'sd300, -16'sd300);
		// A non-digit command leaves record without storing.
		tick(1'b1, CMD_RECORD, 16'sd300, -16'sd300);
		tick(1'b1, CMD_B_UP, 16'sd300, -16'sd300);
		// Load an empty slot, then build a waypoint with one zero axis.
		tick(1'b1, CMD_GO, 16'sd0, 16'sd0);
		tick(1'b1, CMD_GO, 16'sd0, 16'sd0);
		tick(1'b1, 5'd9, 16'sd0, 16'sd0);
		tick(1'b1, CMD_B_UP, 16'sd0, 16'sd100);
		tick(1'b1, CMD_RECORD, 16'sd0, 16'sd100);
		tick(1'b1, 5'd5, 16'sd0, 16'sd100);
		tick(1'b1, CMD_GO, 16'sd0, 16'sd100);
		tick(1'b1, CMD_OTHER, 16'sd0, 16'sd100);
		tick(1'b1, CMD_RECORD, 16'sd0, 16'sd100);
		tick(1'b1, CMD_STOP, 16'sd0, 16'sd100);
		// Playback walks the empty slots and waits on the taught one.
		tick(1'b1, CMD_PLAY, wp_a[3], wp_b[3]);
		tick(1'b1, CMD_A_UP, wp_a[3], wp_b[3]);
		repeat (4) tick(1'b0, CMD_TOP, wp_a[3], wp_b[3]);
		tick(1'b1, CMD_STOP, wp_a[3], wp_b[3]);
		wait_idle();
	endtask

	// Register extremes, each with saturating jogs and a playback run.
	task automatic test_register_extremes();
		int settings [4][4];
		settings = '{'{1, 0, 1, 0}, '{255, 255, 255, 255}, '{255, 0, 0, 3}, '{10, 20, 10, 60}};
		for (int i = 0; i < 4; i++) begin
			src_gaps_on = (i % 2 == 0);
			sink_stalls_on = (i % 2 == 0);
			set_regs(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
			teach_waypoint(5'(i), 32767, -32768);
			tick(1'b1, CMD_A_UP, POS_MAX, POS_MAX);
			tick(1'b1, CMD_B_UP, POS_MAX, POS_MAX);
			tick(1'b1, CMD_A_DOWN, POS_MIN, POS_MIN);
			tick(1'b1, CMD_B_DOWN, POS_MIN, POS_MIN);
			teach_waypoint(5'(NUM_SLOTS - 1 - i), -30000, 30000);
			play_through((settings[i][3] == 255) ? 300 : 60, 1'b1);
			wait_idle();
		end
	endtask

	// Hold the output off long enough that the input stalls.
	task automatic test_output_backpressure();
		src_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (40)
			tick(1'b1, 5'($urandom_range(CMD_B_UP, CMD_A_DOWN)), rand_pos(), rand_pos());
		wait_idle();
	endtask

	// Random teach/play episodes with occasional reconfiguration and noise.
	task automatic test_random_playback();
		int goal;
		goal = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < goal) begin
			src_gaps_on = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0)
				set_regs($urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(1, 40),
					($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9));
			repeat ($urandom_range(1, 4))
				teach_waypoint(5'($urandom_range(0, NUM_SLOTS - 1)), rand_center(), rand_center());
			if ($urandom_range(0, 3) == 0) begin
				tick(1'b1, CMD_GO, rand_pos(), rand_pos());
				tick(1'b1, 5'($urandom_range(0, 31)), rand_pos(), rand_pos());
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 8))
					tick(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), rand_pos(),
						rand_pos());
			play_through($urandom_range(20, 80), 1'b0);
		end
		wait_idle();
	endtask

	initial begin : stimulus
		for (int i = 0; i < NUM_SLOTS; i++) begin
			wp_a[i] = '0;
			wp_b[i] = '0;
		end
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_JOG_STEP;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_register_extremes();
		test_output_backpressure();
		test_random_playback();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
